// ===== src/flash_record_ring_slot_manager_macros.svh =====
// ----------------------------------------------------------------------------
// flash record ring slot manager assertion macros
// shared assertion forms for the slot manager rtl
// ----------------------------------------------------------------------------
`ifndef FLASH_RECORD_RING_SLOT_MANAGER_MACROS_SVH
`define FLASH_RECORD_RING_SLOT_MANAGER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FRRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define FRRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/frrs_pkg.sv =====
// ----------------------------------------------------------------------------
// frrs_pkg
// types, codes and defaults for the flash record ring slot manager
// ----------------------------------------------------------------------------
package frrs_pkg;

    localparam int SLOT_COUNT_DEF       = 256;
    localparam int SLOTS_PER_SECTOR_DEF = 4;

    // command modes
    localparam logic [2:0] MODE_SCAN   = 3'd0;
    localparam logic [2:0] MODE_FINISH = 3'd1;
    localparam logic [2:0] MODE_ALLOC  = 3'd2;
    localparam logic [2:0] MODE_NEXT   = 3'd3;
    localparam logic [2:0] MODE_MARK   = 3'd4;

    // stored slot status codes
    localparam logic [1:0] ST_EMPTY  = 2'd0;
    localparam logic [1:0] ST_DATA   = 2'd1;
    localparam logic [1:0] ST_BACKUP = 2'd2;
    localparam logic [1:0] ST_BAD    = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  slot_index;
        logic [2:0]  slot_status;
        logic        record_valid;
        logic [31:0] record_sequence;
        logic [1:0]  new_status;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  result_slot;
        logic        found;
        logic        erase_sector;
        logic        write_bad_mark;
        logic        ring_full;
        logic [31:0] assigned_sequence;
    } t_out_item;

    // status from the sector remainder unit
    typedef struct packed {
        logic done;
        logic zero;
    } t_mod_stat;

endpackage

// ===== src/frrs_ram.sv =====
// ----------------------------------------------------------------------------
// frrs_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module frrs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/frrs_mod.sv =====
// ----------------------------------------------------------------------------
// frrs_mod
// sector start check of a slot index: reciprocal multiply, then multiply back
// ----------------------------------------------------------------------------
module frrs_mod
    import frrs_pkg::*;
#(
    parameter int VALUE_W = 8,
    parameter int DIVISOR = SLOTS_PER_SECTOR_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_value,
    output t_mod_stat          o_stat
);

    localparam int DIV_W   = $clog2(DIVISOR) + 1;
    localparam int SHIFT   = VALUE_W + $clog2(DIVISOR);
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = VALUE_W + RECIP_W;
    localparam int BACK_W  = VALUE_W + DIV_W;
    // rounded-up reciprocal, exact quotient for every VALUE_W-bit value
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SHIFT + DIVISOR - 1) / DIVISOR);

    logic               r_busy;
    logic               r_done;
    logic               r_zero;
    logic [VALUE_W-1:0] r_val;
    logic [VALUE_W-1:0] r_quot;

    logic [PROD_W-1:0]  prod;
    logic [VALUE_W-1:0] quot;
    logic [BACK_W-1:0]  back;

    assign prod = PROD_W'(i_value) * PROD_W'(RECIP);
    assign quot = VALUE_W'(prod >> SHIFT);
    assign back = BACK_W'(r_quot) * BACK_W'(DIVISOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_quot <= quot;
        end
        if (r_busy) begin
            r_zero <= (back == BACK_W'(r_val));
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.zero = r_zero;

endmodule

// ===== src/flash_record_ring_slot_manager.sv =====
// ----------------------------------------------------------------------------
// flash_record_ring_slot_manager
// slot status ring with write head, read tail and sequence tracking
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-----------------------
//  command  | in        | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//  result   | out       | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
//  scan, finish, mark, unknown modes: the response state loads the result once the output is free
//  allocate: sector remainder unit, then SLOTS_PER_SECTOR erase writes at a
//  sector start (fewer at the ring end), a read and a check per slot walked, then the result is loaded
//  next_data: a read and a check per slot walked, the status ram read being the limit, then the result is loaded
//  after reset every slot of the status ram is cleared, commands stalled
//  one command at a time; a waiting result does not block the next command
// ----------------------------------------------------------------------------
`include "flash_record_ring_slot_manager_macros.svh"

module flash_record_ring_slot_manager
    import frrs_pkg::*;
#(
    parameter int SLOT_COUNT       = SLOT_COUNT_DEF,
    parameter int SLOTS_PER_SECTOR = SLOTS_PER_SECTOR_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOT_COUNT - 1);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_ERASE = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_CHK   = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    function automatic logic [SLOT_W-1:0] f_next(input logic [SLOT_W-1:0] s);
        return (s == LAST) ? '0 : SLOT_W'(s + 1'b1);
    endfunction

    logic [2:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [SLOT_W-1:0] r_start, n_start;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic              r_tail_unset, n_tail_unset;
    logic [31:0]       r_high, n_high;
    logic              r_is_alloc, n_is_alloc;
    logic              r_erase, n_erase;
    t_out_item         r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_data, n_out_data;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [1:0]        ram_wdata;
    logic [1:0]        ram_rdata;
    logic              mod_start;
    t_mod_stat         mod_stat;

    logic              in_xfer;
    logic              idx_ok;
    logic [SLOT_W-1:0] idx_addr;
    logic [SLOT_W-1:0] cur_next;
    logic [SLOT_W-1:0] erase_addr;
    logic              erase_last;
    logic              alloc_hit;
    logic [SLOT_W-1:0] alloc_slot;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign idx_ok     = 32'(i_in_data.slot_index) < 32'(SLOT_COUNT);
    assign idx_addr   = SLOT_W'(i_in_data.slot_index);
    assign cur_next   = f_next(r_cur);
    assign erase_addr = r_head + r_cnt;
    // stop at the sector end or at the end of the ring, whichever comes first
    assign erase_last = (32'(r_cnt) == 32'(SLOTS_PER_SECTOR - 1)) || (erase_addr == LAST);
    assign alloc_hit  = (ram_rdata == ST_EMPTY);
    // full ring: walk came back to the start slot and takes it anyway
    assign alloc_slot = alloc_hit ? r_cur : cur_next;

    frrs_ram #(
        .WIDTH (2),
        .DEPTH (SLOT_COUNT)
    ) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cur),
        .o_rdata (ram_rdata)
    );

    frrs_mod #(
        .VALUE_W (SLOT_W),
        .DIVISOR (SLOTS_PER_SECTOR)
    ) u_sector_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (r_head),
        .o_stat  (mod_stat)
    );

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_cur        = r_cur;
        n_start      = r_start;
        n_head       = r_head;
        n_tail       = r_tail;
        n_tail_unset = r_tail_unset;
        n_high       = r_high;
        n_is_alloc   = r_is_alloc;
        n_erase      = r_erase;
        n_res        = r_res;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_data   = r_out_data;
        ram_we       = 1'b0;
        ram_waddr    = r_cnt;
        ram_wdata    = ST_EMPTY;
        mod_start    = 1'b0;

        unique case (r_state)
            S_CLR: begin
                ram_we = 1'b1;
                if (r_cnt == LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = SLOT_W'(r_cnt + 1'b1);
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_res   = '0;
                    n_erase = 1'b0;
                    n_state = S_RESP;
                    unique case (i_in_data.mode)
                        MODE_SCAN: begin
                            if (idx_ok) begin
                                ram_we    = 1'b1;
                                ram_waddr = idx_addr;
                                ram_wdata = ST_BAD;
                                if (i_in_data.slot_status == 3'(ST_EMPTY) ||
                                    i_in_data.slot_status == 3'(ST_BAD)) begin
                                    ram_wdata = i_in_data.slot_status[1:0];
                                end else if (i_in_data.slot_status == 3'(ST_DATA) ||
                                             i_in_data.slot_status == 3'(ST_BACKUP)) begin
                                    if (i_in_data.record_valid) begin
                                        ram_wdata = i_in_data.slot_status[1:0];
                                        if (r_high < i_in_data.record_sequence) begin
                                            n_high = i_in_data.record_sequence;
                                            n_head = f_next(idx_addr);
                                        end
                                        if (i_in_data.slot_status == 3'(ST_DATA) &&
                                            r_tail_unset) begin
                                            n_tail       = idx_addr;
                                            n_tail_unset = 1'b0;
                                        end
                                    end else begin
                                        n_res.write_bad_mark = 1'b1;
                                    end
                                end else begin
                                    n_res.write_bad_mark = 1'b1;
                                end
                            end
                        end
                        MODE_FINISH: begin
                            if (r_tail_unset) begin
                                n_tail       = r_head;
                                n_tail_unset = 1'b0;
                            end
                        end
                        MODE_ALLOC: begin
                            mod_start  = 1'b1;
                            n_is_alloc = 1'b1;
                            n_state    = S_MOD;
                        end
                        MODE_NEXT: begin
                            if (!r_tail_unset) begin
                                n_is_alloc = 1'b0;
                                n_cur      = r_tail;
                                n_start    = r_tail;
                                n_state    = S_RD;
                            end
                        end
                        MODE_MARK: begin
                            if (idx_ok) begin
                                ram_we       = 1'b1;
                                ram_waddr    = idx_addr;
                                ram_wdata    = i_in_data.new_status;
                                n_tail       = f_next(idx_addr);
                                n_tail_unset = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MOD: begin
                if (mod_stat.done) begin
                    if (mod_stat.zero) begin
                        n_erase = 1'b1;
                        n_cnt   = '0;
                        n_state = S_ERASE;
                    end else begin
                        n_cur   = r_head;
                        n_start = r_head;
                        n_state = S_RD;
                    end
                end
            end
            S_ERASE: begin
                ram_we    = 1'b1;
                ram_waddr = erase_addr;
                ram_wdata = ST_EMPTY;
                if (erase_last) begin
                    n_cur   = r_head;
                    n_start = r_head;
                    n_state = S_RD;
                end else begin
                    n_cnt = SLOT_W'(r_cnt + 1'b1);
                end
            end
            S_RD: begin
                // status of r_cur comes back on the next cycle
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_is_alloc) begin
                    if (alloc_hit || cur_next == r_start) begin
                        ram_we                  = 1'b1;
                        ram_waddr               = alloc_slot;
                        ram_wdata               = ST_DATA;
                        n_head                  = f_next(alloc_slot);
                        n_high                  = r_high + 32'd1;
                        n_res.result_slot       = 8'(alloc_slot);
                        n_res.erase_sector      = r_erase;
                        n_res.ring_full         = !alloc_hit;
                        n_res.assigned_sequence = r_high + 32'd1;
                        n_state                 = S_RESP;
                    end else begin
                        n_cur   = cur_next;
                        n_state = S_RD;
                    end
                end else begin
                    if (ram_rdata == ST_DATA) begin
                        n_res.found       = 1'b1;
                        n_res.result_slot = 8'(r_cur);
                        n_tail            = r_cur;
                        n_state           = S_RESP;
                    end else if (r_cur == r_head) begin
                        n_tail  = r_cur;
                        n_state = S_RESP;
                    end else begin
                        n_cur   = cur_next;
                        n_state = S_RD;
                    end
                end
            end
            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_cnt        <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_tail_unset <= 1'b1;
            r_high       <= '0;
            r_is_alloc   <= 1'b0;
            r_erase      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_tail_unset <= n_tail_unset;
            r_high       <= n_high;
            r_is_alloc   <= n_is_alloc;
            r_erase      <= n_erase;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_start    <= n_start;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `FRRS_ASSERT_IMP(a_head_in_ring, i_clk, i_rst_n, 1'b1, r_head <= LAST, "write head outside ring")
    `FRRS_ASSERT_IMP(a_tail_in_ring, i_clk, i_rst_n, 1'b1, r_tail <= LAST, "read tail outside ring")
    `FRRS_ASSERT_NXT(a_xfer_leaves_idle, i_clk, i_rst_n, in_xfer, r_state != S_IDLE, "command not taken")
    `FRRS_ASSERT_IMP(a_load_from_resp, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_RESP, "result without response")

endmodule
